@@ hw/rtl/dvrt_pkg.sv @@
// Shared types and constants for the distance-vector route table.
// Sequencer state encoding and configuration register map.
// No dependencies.
package dvrt_pkg;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPEN,
      S_RELAX,
      S_WRITE,
      S_EMIT
   } dvrt_state_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int NODE_CNT_W = 4;

   // register index, taken from paddr[2]
   localparam logic REG_NODE_COUNT = 1'b0;

   localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RESET = 4'd8;

   localparam int OUT_DIST_W = 16;
   localparam int OUT_IDX_W  = 3;

endpackage

@@ hw/rtl/distance_vector_route_table.sv @@
// Distance-vector route table: loads a link cost matrix, relaxes it in place
// (Bellman-Ford sweeps) and streams out the route table. Uses dvrt_pkg.
// Loading: one request per cycle while busy is low.
// Run (last entry): each sweep relaxes all n*n pairs, n = active nodes; one
// cost read and two distance reads a cycle, one k step per cycle. Sweeps
// repeat until one changes nothing, then n*n results follow one a cycle
// through the emit and result registers. The receiver cannot stall.
// Reset clears the sequencer and sets node_count to 8; the stores are not
// cleared and must be loaded before use.
module distance_vector_route_table
   import dvrt_pkg::*;
#(
   parameter int MAX_NODES = 8,
   parameter int DIST_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_src_row,
   input  logic [2:0]                        req_dst_col,
   input  logic [15:0]                       req_link_cost,
   input  logic                              req_last_entry,
   output logic                              rsp_valid,
   output logic [OUT_IDX_W-1:0]              rsp_router_id,
   output logic [OUT_IDX_W-1:0]              rsp_target_id,
   output logic [OUT_IDX_W-1:0]              rsp_via_hop,
   output logic [OUT_DIST_W-1:0]             rsp_path_cost,
   output logic                              rsp_last_result,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [CSR_ADDR_W-1:0]             paddr,
   input  logic [CSR_DATA_W-1:0]             pwdata,
   output logic [CSR_DATA_W-1:0]             prdata,
   output logic                              pready
);

   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int WIDE_W = (DIST_BITS > OUT_DIST_W) ? DIST_BITS : OUT_DIST_W;
   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   // storage
   logic [DIST_BITS-1:0] cost_mem [DEPTH];
   logic [DIST_BITS-1:0] dist_mem [DEPTH];
   logic [IDX_W-1:0]     hop_mem  [DEPTH];

   // control and datapath registers
   dvrt_state_type       state_ff, state_in;
   logic [NODE_CNT_W-1:0] node_count_ff;
   logic [IDX_W-1:0]     i_ff, i_in, j_ff, j_in, k_ff, k_in, nm1_ff, nm1_in;
   logic                 first_ff, first_in;
   logic [DIST_BITS-1:0] best_ff, best_in;
   logic [IDX_W-1:0]     hop_ff, hop_in;
   logic                 chg_ff, chg_in;
   logic                 sweep_changed_ff, sweep_changed_in;
   logic                 emit_v_ff, emit_v_in, emit_last_ff, emit_last_in;
   logic [IDX_W-1:0]     emit_i_ff, emit_i_in, emit_j_ff, emit_j_in;
   logic                 rsp_valid_ff, rsp_last_ff;
   logic [OUT_IDX_W-1:0] rsp_router_ff, rsp_target_ff, rsp_hop_ff;
   logic [OUT_DIST_W-1:0] rsp_cost_ff;

   // memory read data
   logic [DIST_BITS-1:0] dist_rd_a_ff, dist_rd_b_ff, cost_rd_ff;
   logic [IDX_W-1:0]     hop_rd_ff;

   // memory controls
   logic [ADDR_W-1:0]    addr_a, addr_b, addr_c, wr_addr;
   logic                 cost_we, dist_we, hop_we;
   logic [DIST_BITS-1:0] cost_wd, dist_wd;
   logic [IDX_W-1:0]     hop_wd;

   // load decode
   logic                 accept, ld_ok, ld_diag, ld_sat;
   logic [WIDE_W-1:0]    ld_cost_wide;
   logic [DIST_BITS-1:0] ld_cost;
   logic [IDX_W-1:0]     ld_row, ld_col, nm1_calc;

   // relaxation datapath
   logic                 k_last, pair_last;
   logic [IDX_W-1:0]     k_nx;
   logic [DIST_BITS-1:0] best_cur, dist_kj, via;
   logic [DIST_BITS:0]   via_sum;
   logic                 take;
   logic [WIDE_W-1:0]    out_wide;

   logic                 csr_wr;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_wr && (paddr[2] == REG_NODE_COUNT)) begin
         node_count_ff <= pwdata[NODE_CNT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_NODE_COUNT) begin
         prdata = {{(CSR_DATA_W-NODE_CNT_W){1'b0}}, node_count_ff};
      end
   end

   // ---------------- load decode ----------------
   assign busy   = (state_ff != S_IDLE) | emit_v_ff;
   assign accept = start & ~busy;

   assign ld_ok   = (int'(req_src_row) < MAX_NODES) && (int'(req_dst_col) < MAX_NODES);
   assign ld_row  = IDX_W'(req_src_row);
   assign ld_col  = IDX_W'(req_dst_col);
   assign ld_diag = (req_src_row == req_dst_col);
   assign ld_cost_wide = WIDE_W'(req_link_cost);
   assign ld_sat  = (req_link_cost == 16'hFFFF) || (ld_cost_wide > WIDE_W'(DIST_MAX));
   assign ld_cost = ld_diag ? '0 : (ld_sat ? DIST_MAX : DIST_BITS'(ld_cost_wide));

   always_comb begin
      if (node_count_ff == '0) begin
         nm1_calc = '0;
      end else if (int'(node_count_ff) > MAX_NODES) begin
         nm1_calc = IDX_W'(MAX_NODES - 1);
      end else begin
         nm1_calc = IDX_W'(int'(node_count_ff) - 1);
      end
   end

   // ---------------- relaxation datapath ----------------
   assign k_last    = (k_ff == nm1_ff);
   assign pair_last = (i_ff == nm1_ff) && (j_ff == nm1_ff);
   assign k_nx      = k_ff + 1'b1;

   assign best_cur = first_ff ? dist_rd_a_ff : best_ff;
   // forward the running best when k reaches the source row
   assign dist_kj  = (k_ff == i_ff) ? best_cur : dist_rd_b_ff;
   assign via_sum  = {1'b0, cost_rd_ff} + {1'b0, dist_kj};
   assign via      = via_sum[DIST_BITS] ? DIST_MAX : via_sum[DIST_BITS-1:0];
   assign take     = (via < best_cur);

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_last_entry) state_in = S_OPEN;
         end
         S_OPEN: begin
            state_in = S_RELAX;
         end
         S_RELAX: begin
            if (k_last) state_in = S_WRITE;
         end
         S_WRITE: begin
            if (pair_last) begin
               state_in = (sweep_changed_ff | chg_ff) ? S_OPEN : S_EMIT;
            end else begin
               state_in = S_OPEN;
            end
         end
         S_EMIT: begin
            if (pair_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      nm1_in = nm1_ff;
      first_in = first_ff;
      best_in = best_ff;
      hop_in = hop_ff;
      chg_in = chg_ff;
      sweep_changed_in = sweep_changed_ff;
      emit_v_in = 1'b0;
      emit_last_in = 1'b0;
      emit_i_in = i_ff;
      emit_j_in = j_ff;
      addr_a = {i_ff, j_ff};
      addr_b = {k_ff, j_ff};
      addr_c = {i_ff, k_ff};
      wr_addr = {i_ff, j_ff};
      cost_we = 1'b0;
      dist_we = 1'b0;
      hop_we = 1'b0;
      cost_wd = ld_cost;
      dist_wd = best_ff;
      hop_wd = hop_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               wr_addr = {ld_row, ld_col};
               cost_we = ld_ok;
               dist_we = ld_ok;
               hop_we = ld_ok;
               dist_wd = ld_cost;
               hop_wd = ld_col;
               if (req_last_entry) begin
                  i_in = '0;
                  j_in = '0;
                  nm1_in = nm1_calc;
                  sweep_changed_in = 1'b0;
               end
            end
         end
         S_OPEN: begin
            addr_b = {{IDX_W{1'b0}}, j_ff};
            addr_c = {i_ff, {IDX_W{1'b0}}};
            k_in = '0;
            first_in = 1'b1;
         end
         S_RELAX: begin
            addr_b = {k_nx, j_ff};
            addr_c = {i_ff, k_nx};
            first_in = 1'b0;
            best_in = take ? via : best_cur;
            hop_in = take ? k_ff : hop_ff;
            chg_in = first_ff ? take : (chg_ff | take);
            k_in = k_nx;
         end
         S_WRITE: begin
            dist_we = chg_ff;
            hop_we = chg_ff;
            sweep_changed_in = sweep_changed_ff | chg_ff;
            if (j_ff == nm1_ff) begin
               j_in = '0;
               i_in = pair_last ? '0 : i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
            if (pair_last) sweep_changed_in = 1'b0;
         end
         S_EMIT: begin
            emit_v_in = 1'b1;
            emit_last_in = pair_last;
            if (j_ff == nm1_ff) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         default: begin
            i_in = i_ff;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sweep_changed_ff <= 1'b0;
         emit_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_changed_ff <= sweep_changed_in;
         emit_v_ff <= emit_v_in;
         rsp_valid_ff <= emit_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      nm1_ff <= nm1_in;
      first_ff <= first_in;
      best_ff <= best_in;
      hop_ff <= hop_in;
      chg_ff <= chg_in;
      emit_last_ff <= emit_last_in;
      emit_i_ff <= emit_i_in;
      emit_j_ff <= emit_j_in;
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (cost_we) cost_mem[wr_addr] <= cost_wd;
      cost_rd_ff <= cost_mem[addr_c];
   end

   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[wr_addr] <= dist_wd;
      dist_rd_a_ff <= dist_mem[addr_a];
      dist_rd_b_ff <= dist_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (hop_we) hop_mem[wr_addr] <= hop_wd;
      hop_rd_ff <= hop_mem[addr_a];
   end

   // ---------------- result stage ----------------
   assign out_wide = WIDE_W'(dist_rd_a_ff);

   always_ff @(posedge clock) begin
      if (emit_v_ff) begin
         rsp_router_ff <= OUT_IDX_W'(emit_i_ff);
         rsp_target_ff <= OUT_IDX_W'(emit_j_ff);
         rsp_hop_ff <= OUT_IDX_W'(hop_rd_ff);
         rsp_cost_ff <= (out_wide > WIDE_W'(16'hFFFF)) ? 16'hFFFF
                                                        : out_wide[OUT_DIST_W-1:0];
         rsp_last_ff <= emit_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_router_id   = rsp_router_ff;
   assign rsp_target_id   = rsp_target_ff;
   assign rsp_via_hop     = rsp_hop_ff;
   assign rsp_path_cost   = rsp_cost_ff;
   assign rsp_last_result = rsp_last_ff;

   // ---------------- assertions ----------------
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == S_IDLE))
      else $error("request accepted outside idle");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(emit_v_ff))
      else $error("result without a table read");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |=> !rsp_valid)
      else $error("result after the final table entry");

   a_write_after_relax: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> ($past(state_ff) == S_RELAX && $past(k_last)))
      else $error("write-back before the k loop finished");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OPEN && $past(state_ff) == S_IDLE)
         |-> $past(accept && req_last_entry))
      else $error("run started without a final entry");

endmodule

@@ tb/tb_distance_vector_route_table.sv @@
// Self-checking testbench for distance_vector_route_table: drives cost-matrix requests,
// predicts or takes from typed rows each routing table emitted after a final entry and checks every result in order.
// Depends on dvrt_pkg and the distance_vector_route_table RTL.
module tb_distance_vector_route_table
   import dvrt_pkg::*;
();

   localparam int ITEM_TARGET = 460;
   localparam int CYCLE_LIMIT = 12_000_000;
   localparam int DIR_N       = 18;
   localparam int TYPED_N     = 6;
   localparam int NODES       = 8;
   localparam int MAX_GAP     = 16;
   localparam int IDLE_TAIL   = 8;
   localparam int PRINT_CAP   = 40;
   localparam logic [15:0] NO_LINK = 16'hFFFF;
   localparam logic [CSR_ADDR_W-1:0] NODE_COUNT_ADDR = CSR_ADDR_W'({REG_NODE_COUNT, 2'b00});

   typedef struct packed {
      logic [OUT_IDX_W-1:0]  router_id;
      logic [OUT_IDX_W-1:0]  target_id;
      logic [OUT_IDX_W-1:0]  via_hop;
      logic [OUT_DIST_W-1:0] path_cost;
      logic                  last_result;
   } route_entry_type;

   typedef struct packed {
      logic                  cfg_en;
      logic [NODE_CNT_W-1:0] cfg_val;
      logic [2:0]            src_row;
      logic [2:0]            dst_col;
      logic [15:0]           link_cost;
      logic                  last_entry;
      int                    typed_n;
   } link_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [2:0]            req_src_row;
   logic [2:0]            req_dst_col;
   logic [15:0]           req_link_cost;
   logic                  req_last_entry;
   logic                  rsp_valid;
   logic [OUT_IDX_W-1:0]  rsp_router_id;
   logic [OUT_IDX_W-1:0]  rsp_target_id;
   logic [OUT_IDX_W-1:0]  rsp_via_hop;
   logic [OUT_DIST_W-1:0] rsp_path_cost;
   logic                  rsp_last_result;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic [15:0]           link_cost_tab [NODES*NODES];
   logic [15:0]           route_dist_tab [NODES*NODES];
   logic [2:0]            route_hop_tab [NODES*NODES];
   logic [NODE_CNT_W-1:0] node_cfg;

   route_entry_type pending_routes[$];
   route_entry_type rsp_want;
   link_row_type    link_rows [DIR_N];
   route_entry_type typed_routes [TYPED_N];
   int              typed_pos;
   int              requests_sent;
   int              error_count;
   int              cycle_count;
   bit              burst_mode;

   distance_vector_route_table u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_src_row     (req_src_row),
      .req_dst_col     (req_dst_col),
      .req_link_cost   (req_link_cost),
      .req_last_entry  (req_last_entry),
      .rsp_valid       (rsp_valid),
      .rsp_router_id   (rsp_router_id),
      .rsp_target_id   (rsp_target_id),
      .rsp_via_hop     (rsp_via_hop),
      .rsp_path_cost   (rsp_path_cost),
      .rsp_last_result (rsp_last_result),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("mismatch %s: got %0d want %0d", what, got, want);
      end
   endtask

   // store one link cost and, on a final entry, relax the table and queue its rows if queue_rows is set
   task automatic load_link(input logic [2:0] s, input logic [2:0] d, input logic [15:0] c,
                            input logic fin, input bit queue_rows);
      int              n;
      int              slot;
      bit              changed;
      logic [16:0]     via;
      route_entry_type r;
      slot = s * NODES + d;
      link_cost_tab[slot]  = (s == d) ? 16'd0 : c;
      route_dist_tab[slot] = (s == d) ? 16'd0 : c;
      route_hop_tab[slot]  = d;
      if (!fin) return;
      n = (node_cfg == 0) ? 1 : (node_cfg > NODES) ? NODES : int'(node_cfg);
      do begin
         changed = 1'b0;
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               for (int k = 0; k < n; k++) begin
                  via = {1'b0, link_cost_tab[i*NODES+k]} + {1'b0, route_dist_tab[k*NODES+j]};
                  if (via > {1'b0, NO_LINK}) via = {1'b0, NO_LINK};
                  if (via[15:0] < route_dist_tab[i*NODES+j]) begin
                     route_dist_tab[i*NODES+j] = via[15:0];
                     route_hop_tab[i*NODES+j]  = 3'(k);
                     changed = 1'b1;
                  end
               end
            end
         end
      end while (changed);
      if (!queue_rows) return;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            r.router_id   = 3'(i);
            r.target_id   = 3'(j);
            r.via_hop     = route_hop_tab[i*NODES+j];
            r.path_cost   = route_dist_tab[i*NODES+j];
            r.last_result = (i == n - 1) && (j == n - 1);
            pending_routes.push_back(r);
         end
      end
   endtask

   task automatic csr_cycle(input bit is_write, input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = is_write;
      paddr   = NODE_COUNT_ADDR;
      pwdata  = wdata;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      if (is_write) node_cfg = wdata[NODE_CNT_W-1:0];
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_node_count(input logic [NODE_CNT_W-1:0] v);
      logic [CSR_DATA_W-1:0] rd;
      csr_cycle(1'b1, CSR_DATA_W'(v), rd);
      csr_cycle(1'b0, '0, rd);
      if (rd[NODE_CNT_W-1:0] !== v) report_mismatch("node_count readback", rd, v);
   endtask

   // hold off until every queued row has arrived and the block is quiet
   task automatic wait_idle();
      start = 1'b0;
      while (pending_routes.size() != 0 || busy) @(negedge clock);
      repeat (IDLE_TAIL) @(negedge clock);
   endtask

   task automatic send_request(input logic [2:0] s, input logic [2:0] d, input logic [15:0] c,
                               input logic fin, input int typed_n);
      int gap;
      req_src_row    = s;
      req_dst_col    = d;
      req_link_cost  = c;
      req_last_entry = fin;
      start          = 1'b1;
      do @(posedge clock); while (busy);
      load_link(s, d, c, fin, typed_n < 0);
      for (int i = 0; i < typed_n; i++) begin
         pending_routes.push_back(typed_routes[typed_pos]);
         typed_pos++;
      end
      requests_sent++;
      @(negedge clock);
      gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [15:0] rand_cost();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return NO_LINK;
         2: return 16'hFFFE;
         3: return 16'($urandom_range(1, 15));
         4, 5: return 16'($urandom_range(1, 200));
         6: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(16'h7000, 16'hFFFF));
      endcase
   endfunction

   function automatic logic [NODE_CNT_W-1:0] rand_node_count();
      case ($urandom_range(0, 5))
         0: return 4'd0;
         1: return 4'd1;
         2: return 4'd8;
         3: return 4'd15;
         default: return 4'($urandom_range(0, 15));
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_routes.size() == 0) begin
            report_mismatch("result with nothing pending, router_id", rsp_router_id, 0);
         end else begin
            rsp_want = pending_routes.pop_front();
            if (rsp_router_id !== rsp_want.router_id)
               report_mismatch("router_id", rsp_router_id, rsp_want.router_id);
            if (rsp_target_id !== rsp_want.target_id)
               report_mismatch("target_id", rsp_target_id, rsp_want.target_id);
            if (rsp_via_hop !== rsp_want.via_hop)
               report_mismatch("via_hop", rsp_via_hop, rsp_want.via_hop);
            if (rsp_path_cost !== rsp_want.path_cost)
               report_mismatch("path_cost", rsp_path_cost, rsp_want.path_cost);
            if (rsp_last_result !== rsp_want.last_result)
               report_mismatch("last_result", rsp_last_result, rsp_want.last_result);
         end
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] rd;
      int                    loads;
      reset          = 1'b1;
      start          = 1'b0;
      req_src_row    = '0;
      req_dst_col    = '0;
      req_link_cost  = '0;
      req_last_entry = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      cycle_count    = 0;
      error_count    = 0;
      requests_sent  = 0;
      typed_pos      = 0;
      burst_mode     = 1'b0;
      node_cfg       = NODE_COUNT_RESET;
      for (int c = 0; c < NODES*NODES; c++) begin
         link_cost_tab[c]  = '0;
         route_dist_tab[c] = '0;
         route_hop_tab[c]  = '0;
      end

      // cfg_en, cfg_val, src, dst, cost, last, typed rows (-1: predicted)
      link_rows = '{
         '{1'b1, 4'd0, 3'd0, 3'd0, 16'h1234, 1'b1,  1},
         '{1'b1, 4'd2, 3'd0, 3'd1, 16'd5,    1'b0,  0},
         '{1'b0, 4'd0, 3'd1, 3'd0, 16'hFFFF, 1'b0,  0},
         '{1'b0, 4'd0, 3'd1, 3'd1, 16'hFFFF, 1'b0,  0},
         '{1'b0, 4'd0, 3'd1, 3'd1, 16'd7,    1'b1,  4},
         '{1'b1, 4'd3, 3'd0, 3'd2, 16'hFFFF, 1'b0, -1},
         '{1'b0, 4'd0, 3'd2, 3'd0, 16'hFFFE, 1'b0, -1},
         '{1'b0, 4'd0, 3'd2, 3'd1, 16'd0,    1'b0, -1},
         '{1'b0, 4'd0, 3'd1, 3'd2, 16'h8000, 1'b0, -1},
         '{1'b0, 4'd0, 3'd2, 3'd2, 16'h5555, 1'b1, -1},
         '{1'b1, 4'd4, 3'd0, 3'd3, 16'hAAAA, 1'b0, -1},
         '{1'b0, 4'd0, 3'd3, 3'd0, 16'd1,    1'b0, -1},
         '{1'b0, 4'd0, 3'd1, 3'd3, 16'h7FFF, 1'b0, -1},
         '{1'b0, 4'd0, 3'd3, 3'd1, 16'hFFFF, 1'b0, -1},
         '{1'b0, 4'd0, 3'd2, 3'd3, 16'h00FF, 1'b0, -1},
         '{1'b0, 4'd0, 3'd3, 3'd2, 16'hFF00, 1'b0, -1},
         '{1'b0, 4'd0, 3'd3, 3'd3, 16'd3,    1'b1, -1},
         '{1'b1, 4'd1, 3'd0, 3'd0, 16'hFFFF, 1'b1,  1}
      };
      typed_routes = '{
         '{3'd0, 3'd0, 3'd0, 16'd0,     1'b1},
         '{3'd0, 3'd0, 3'd0, 16'd0,     1'b0},
         '{3'd0, 3'd1, 3'd1, 16'd5,     1'b0},
         '{3'd1, 3'd0, 3'd0, 16'hFFFF,  1'b0},
         '{3'd1, 3'd1, 3'd1, 16'd0,     1'b1},
         '{3'd0, 3'd0, 3'd0, 16'd0,     1'b1}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_cycle(1'b0, '0, rd);
      if (rd[NODE_CNT_W-1:0] !== NODE_COUNT_RESET)
         report_mismatch("node_count after reset", rd, NODE_COUNT_RESET);

      for (int r = 0; r < DIR_N; r++) begin
         if (link_rows[r].cfg_en) begin
            wait_idle();
            set_node_count(link_rows[r].cfg_val);
         end
         send_request(link_rows[r].src_row, link_rows[r].dst_col, link_rows[r].link_cost,
                      link_rows[r].last_entry, link_rows[r].typed_n);
      end

      // fill the whole matrix so that any node count reads written entries only
      wait_idle();
      set_node_count(4'd8);
      for (int c = 0; c < NODES*NODES; c++) begin
         send_request(3'(c / NODES), 3'(c % NODES), rand_cost(), c == NODES*NODES - 1, -1);
      end

      while (requests_sent < ITEM_TARGET) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 1) begin
            wait_idle();
            set_node_count(rand_node_count());
         end
         loads = $urandom_range(0, 9);
         if ($urandom_range(0, 9) == 0) loads = $urandom_range(20, 40);
         repeat (loads) begin
            send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rand_cost(),
                         $urandom_range(0, 19) == 0, -1);
         end
         if ($urandom_range(0, 5) == 0) wait_idle();
         send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rand_cost(),
                      1'b1, -1);
      end

      start = 1'b0;
      while (pending_routes.size() != 0) @(negedge clock);
      repeat (4 * IDLE_TAIL) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
